>>> rtl/mdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdq_pkg;

    // deque table
    localparam int NUM_QUEUES   = 1024;
    localparam int QID_W        = 10;

    // node pool
    localparam int POOL_ENTRIES = 4096;
    localparam int NODE_W       = 12;
    localparam int CNT_W        = 13;
    localparam int VALUE_WIDTH  = 32;

    // stream payload widths
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int PUSH_VALUE_W = 32;
    localparam int POP_VALUE_W  = 32;

    // deque table entry: {nonempty, head, tail}
    localparam int QENT_W       = 1 + 2 * NODE_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [NODE_W-1:0] node_idx_t;

    typedef struct packed {
        logic      nonempty;
        node_idx_t head;
        node_idx_t tail;
    } qent_t;

endpackage

`default_nettype wire

>>> rtl/mdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/multi_deque_linked_pool_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Many double-ended queues sharing one pool of doubly linked nodes.
// Input channel (s_*): s_tuser carries the opcode (push back, push front,
// pop front, pop back), s_tdata the queue number and the value to push.
// Result channel (m_*): one transaction per input item, m_tuser holds the
// status (ok, pop from empty queue, pool full on push), m_tdata the popped
// value, zero for pushes and failed pops.
// Items are handled one at a time. A push or a pop from an empty queue goes
// from acceptance through the table read step to the output step; a successful
// pop adds a pop step between them. The next item is taken in the cycle its
// predecessor's result is loaded.
// The steps come from the registered reads of the deque table and node
// memories: a pop reads the table, then the victim node and its link.
// After reset the block sweeps the deque table, one entry a cycle, marking
// every queue empty; s_tready stays low until all NUM_QUEUES (1024) are cleared.
// Freed nodes go onto a last-in first-out free list linked through the next
// link memory; never used nodes are handed out by a counter.
// The result sits in an output register; when the receiver stalls, the
// result holds and the block stops taking new items after finishing the
// one in progress.
module multi_deque_linked_pool_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [9:0] queue_id, [41:10] push_value, [47:42] zero
    input  wire logic [mdq_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] opcode
    input  wire logic [mdq_pkg::OP_W-1:0]          s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] pop_value
    output logic      [mdq_pkg::M_TDATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic      [mdq_pkg::STATUS_W-1:0]      m_tuser
);

    import mdq_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READQ = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [QID_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [QID_W-1:0]        qid_reg, qid_next;
    logic [VALUE_WIDTH-1:0]  pv_reg, pv_next;
    node_idx_t               hd_reg, hd_next;
    node_idx_t               tl_reg, tl_next;
    logic [CNT_W-1:0]        fresh_reg, fresh_next;
    node_idx_t               ftop_reg, ftop_next;
    logic [CNT_W-1:0]        fcnt_reg, fcnt_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;
    logic [POP_VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]     m_user_reg, m_user_next;
    logic [POP_VALUE_W-1:0]  m_data_reg, m_data_next;

    // memory ports
    logic                    q_we;
    logic [QID_W-1:0]        q_waddr, q_raddr;
    qent_t                   q_wdata, q_rdata;
    logic                    nx_we;
    node_idx_t               nx_waddr, nx_raddr, nx_wdata, nx_rdata;
    logic                    pr_we;
    node_idx_t               pr_waddr, pr_raddr, pr_wdata, pr_rdata;
    logic                    val_we;
    node_idx_t               val_waddr, val_raddr;
    logic [VALUE_WIDTH-1:0]  val_wdata, val_rdata;

    logic                    out_free;
    logic                    accept;
    logic [QID_W-1:0]        in_qid;
    logic [VALUE_WIDTH-1:0]  in_pv;
    logic                    is_push;
    node_idx_t               new_node;
    logic                    alloc_ok;
    node_idx_t               victim;

    assign in_qid   = s_tdata[QID_W-1:0];
    assign in_pv    = VALUE_WIDTH'(s_tdata[QID_W +: PUSH_VALUE_W]);
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_OUT) && out_free);
    assign accept   = s_tvalid && s_tready;
    assign is_push  = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT);
    assign victim   = (op_reg == OP_POP_FRONT) ? hd_reg : tl_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);

    // deque table and node memories
    mdq_ram #(.WIDTH(QENT_W), .DEPTH(NUM_QUEUES)) u_qtab (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    mdq_ram #(.WIDTH(NODE_W), .DEPTH(POOL_ENTRIES)) u_next (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(nx_raddr), .rdata(nx_rdata)
    );

    mdq_ram #(.WIDTH(NODE_W), .DEPTH(POOL_ENTRIES)) u_prev (
        .aclk(aclk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
        .raddr(pr_raddr), .rdata(pr_rdata)
    );

    mdq_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_ENTRIES)) u_value (
        .aclk(aclk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
        .raddr(val_raddr), .rdata(val_rdata)
    );

    // node allocation: free list first, then never used nodes
    always_comb begin
        alloc_ok = 1'b1;
        new_node = ftop_reg;
        if (fcnt_reg != '0) begin
            new_node = ftop_reg;
        end else if (fresh_reg < CNT_W'(POOL_ENTRIES)) begin
            new_node = fresh_reg[NODE_W-1:0];
        end else begin
            alloc_ok = 1'b0;
        end
    end

    // sequencer: read, modify and write back the deque table and node links
    always_comb begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        op_next         = op_reg;
        qid_next        = qid_reg;
        pv_next         = pv_reg;
        hd_next         = hd_reg;
        tl_next         = tl_reg;
        fresh_next      = fresh_reg;
        ftop_next       = ftop_reg;
        fcnt_next       = fcnt_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;

        q_we      = 1'b0;
        q_waddr   = qid_reg;
        q_wdata   = '0;
        q_raddr   = in_qid;
        nx_we     = 1'b0;
        nx_waddr  = '0;
        nx_wdata  = '0;
        nx_raddr  = ftop_reg;
        pr_we     = 1'b0;
        pr_waddr  = '0;
        pr_wdata  = '0;
        pr_raddr  = tl_reg;
        val_we    = 1'b0;
        val_waddr = new_node;
        val_wdata = pv_reg;
        val_raddr = victim;

        // result taken by the receiver
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                q_we    = 1'b1;
                q_waddr = clr_idx_reg;
                q_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == QID_W'(NUM_QUEUES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE, S_OUT: begin
                if (state_reg == S_OUT && out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = res_value_reg;
                    state_next   = S_IDLE;
                end
                if (accept) begin
                    op_next    = s_tuser;
                    qid_next   = in_qid;
                    pv_next    = in_pv;
                    state_next = S_READQ;
                end
            end
            S_READQ: begin
                hd_next        = q_rdata.head;
                tl_next        = q_rdata.tail;
                res_status_next = ST_OK;
                res_value_next  = '0;
                state_next      = S_OUT;
                if (is_push) begin
                    if (!alloc_ok) begin
                        res_status_next = ST_FULL;
                    end else begin
                        if (fcnt_reg != '0) begin
                            ftop_next = nx_rdata;
                            fcnt_next = fcnt_reg - 1'b1;
                        end else begin
                            fresh_next = fresh_reg + 1'b1;
                        end
                        val_we  = 1'b1;
                        q_we    = 1'b1;
                        if (!q_rdata.nonempty) begin
                            q_wdata = '{nonempty: 1'b1, head: new_node, tail: new_node};
                        end else if (op_reg == OP_PUSH_BACK) begin
                            pr_we    = 1'b1;
                            pr_waddr = new_node;
                            pr_wdata = q_rdata.tail;
                            nx_we    = 1'b1;
                            nx_waddr = q_rdata.tail;
                            nx_wdata = new_node;
                            q_wdata  = '{nonempty: 1'b1, head: q_rdata.head,
                                         tail: new_node};
                        end else begin
                            nx_we    = 1'b1;
                            nx_waddr = new_node;
                            nx_wdata = q_rdata.head;
                            pr_we    = 1'b1;
                            pr_waddr = q_rdata.head;
                            pr_wdata = new_node;
                            q_wdata  = '{nonempty: 1'b1, head: new_node,
                                         tail: q_rdata.tail};
                        end
                    end
                end else begin
                    if (!q_rdata.nonempty) begin
                        res_status_next = ST_EMPTY;
                    end else begin
                        // fetch victim value and both neighbor links
                        val_raddr  = (op_reg == OP_POP_FRONT) ? q_rdata.head
                                                              : q_rdata.tail;
                        nx_raddr   = q_rdata.head;
                        pr_raddr   = q_rdata.tail;
                        state_next = S_POP;
                    end
                end
            end
            S_POP: begin
                res_status_next = ST_OK;
                res_value_next  = POP_VALUE_W'(signed'(val_rdata));
                q_we = 1'b1;
                if (hd_reg == tl_reg) begin
                    q_wdata = '{nonempty: 1'b0, head: hd_reg, tail: tl_reg};
                end else if (op_reg == OP_POP_FRONT) begin
                    q_wdata = '{nonempty: 1'b1, head: nx_rdata, tail: tl_reg};
                end else begin
                    q_wdata = '{nonempty: 1'b1, head: hd_reg, tail: pr_rdata};
                end
                // push the freed node onto the free list
                nx_we     = 1'b1;
                nx_waddr  = victim;
                nx_wdata  = ftop_reg;
                ftop_next = victim;
                fcnt_next = fcnt_reg + 1'b1;
                state_next = S_OUT;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            fresh_reg   <= '0;
            ftop_reg    <= '0;
            fcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            fresh_reg   <= fresh_next;
            ftop_reg    <= ftop_next;
            fcnt_reg    <= fcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        qid_reg        <= qid_next;
        pv_reg         <= pv_next;
        hd_reg         <= hd_next;
        tl_reg         <= tl_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_user_reg     <= m_user_next;
        m_data_reg     <= m_data_next;
    end

    // free nodes never outnumber the nodes ever handed out
    assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= fresh_reg)
        else $error("free list count exceeds allocated nodes");

    // never used node counter stays within the pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= CNT_W'(POOL_ENTRIES))
        else $error("fresh node counter beyond pool size");

    // no item taken during the table sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input ready during table clear");

    // the pop step always follows a table read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |-> ($past(state_reg) == S_READQ))
        else $error("pop step entered out of sequence");

    // a pop step always returns a node to the free list
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP) |=> (fcnt_reg == $past(fcnt_reg) + 1'b1))
        else $error("freed node not counted");

endmodule

`default_nettype wire

>>> test/multi_deque_linked_pool_core_tb.sv
`timescale 1ns / 1ps

module multi_deque_linked_pool_core_tb;
    import mdq_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int OPS_PER_PHASE    = 450;
    localparam int HOT_QUEUES       = 6;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [POP_VALUE_W-1:0] pop_value;
    } deque_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // predicted deque contents and pool occupancy
    logic [PUSH_VALUE_W-1:0] deque_contents [NUM_QUEUES][$];
    int unsigned             nodes_in_use = 0;
    deque_result_t           expected_results [$];
    deque_result_t           oldest_result;

    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    int unsigned hold_request    = 0;
    int unsigned hold_left       = 0;
    int unsigned ops_sent        = 0;
    int unsigned results_checked = 0;
    int unsigned empty_pops      = 0;
    int unsigned full_pushes     = 0;
    int unsigned error_count     = 0;
    int unsigned cycle_count     = 0;

    multi_deque_linked_pool_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // watchdog
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("[multi_deque_linked_pool_core] ERROR");
                $finish;
            end
        end
    end

    // result receiver: random stalls plus requested long hold-offs
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing pending: status %0d, pop_value 0x%08h",
                       m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_result = expected_results[0];
                expected_results.delete(0);
                results_checked++;
                if (m_tuser !== oldest_result.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           oldest_result.status, m_tuser);
                    error_count++;
                end
                if (m_tdata !== oldest_result.pop_value) begin
                    $error("pop_value mismatch: expected 0x%08h, actual 0x%08h",
                           oldest_result.pop_value, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // deque behavior: the pool is full once every node holds a value
    function automatic deque_result_t predict_op(input logic [OP_W-1:0] op,
                                                 input logic [QID_W-1:0] qid,
                                                 input logic [PUSH_VALUE_W-1:0] value);
        deque_result_t res;
        res.status    = ST_OK;
        res.pop_value = '0;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            if (nodes_in_use >= POOL_ENTRIES) begin
                res.status = ST_FULL;
                full_pushes++;
            end else begin
                nodes_in_use++;
                if (op == OP_PUSH_BACK)
                    deque_contents[qid].insert(deque_contents[qid].size(), value);
                else
                    deque_contents[qid].insert(0, value);
            end
        end else if (deque_contents[qid].size() == 0) begin
            res.status = ST_EMPTY;
            empty_pops++;
        end else begin
            nodes_in_use--;
            if (op == OP_POP_FRONT) begin
                res.pop_value = deque_contents[qid][0];
                deque_contents[qid].delete(0);
            end else begin
                res.pop_value = deque_contents[qid][deque_contents[qid].size() - 1];
                deque_contents[qid].delete(deque_contents[qid].size() - 1);
            end
        end
        return res;
    endfunction

    function automatic logic [PUSH_VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_push();
        return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic logic [OP_W-1:0] pick_pop();
        return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    // offer one transaction, called and returning at a falling edge
    task automatic send_op(input logic [OP_W-1:0] op, input logic [QID_W-1:0] qid,
                           input logic [PUSH_VALUE_W-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - QID_W - PUSH_VALUE_W){1'b0}}, value, qid};
        do @(posedge aclk); while (!s_tready);
        expected_results.insert(expected_results.size(), predict_op(op, qid, value));
        ops_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (expected_results.size() != 0);
    endtask

    // empty pops, single-node pops from both ends, value and queue extremes
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(OP_POP_FRONT,  '0, '0);
        send_op(OP_POP_BACK,   '1, '1);
        send_op(OP_PUSH_BACK,  '0, 32'h7fff_ffff);
        send_op(OP_POP_BACK,   '0, '0);
        send_op(OP_PUSH_FRONT, '0, 32'h8000_0000);
        send_op(OP_POP_FRONT,  '0, '0);
        send_op(OP_PUSH_BACK,  '1, '1);
        send_op(OP_PUSH_BACK,  '1, '0);
        send_op(OP_PUSH_FRONT, '1, 32'h0000_0001);
        send_op(OP_PUSH_FRONT, '1, 32'h5555_5555);
        send_op(OP_PUSH_BACK,  10'h2aa, 32'haaaa_aaaa);
        send_op(OP_PUSH_FRONT, 10'h155, 32'h5555_5555);
        send_op(OP_POP_FRONT,  '1, '0);
        send_op(OP_POP_BACK,   '1, '0);
        send_op(OP_POP_BACK,   '1, '0);
        send_op(OP_POP_FRONT,  '1, '0);
        send_op(OP_POP_FRONT,  '1, '0);
        send_op(OP_POP_BACK,   10'h2aa, '0);
        send_op(OP_POP_FRONT,  10'h155, '0);
        send_op(OP_POP_BACK,   10'h155, '0);
        wait_for_results();
    endtask

    // mixed traffic on a few busy deques plus scattered and edge queues
    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        logic [QID_W-1:0] hot [HOT_QUEUES];
        logic [QID_W-1:0] qid;
        int               push_pct;
        int               pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        foreach (hot[i])
            hot[i] = QID_W'($urandom_range(NUM_QUEUES - 1));
        for (int n = 0; n < OPS_PER_PHASE; n++) begin
            // grow the deques in the first half, shrink them in the second
            push_pct = (n < OPS_PER_PHASE / 2) ? 62 : 38;
            pick     = $urandom_range(99);
            if (pick < 70)
                qid = hot[$urandom_range(HOT_QUEUES - 1)];
            else if (pick < 90)
                qid = QID_W'($urandom_range(NUM_QUEUES - 1));
            else
                qid = $urandom_range(1) ? '1 : '0;
            if ($urandom_range(99) < push_pct)
                send_op(pick_push(), qid, pick_value());
            else
                send_op(pick_pop(), qid, pick_value());
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(52, 0);
        run_random_phase(0, 52);
        run_random_phase(29, 29);
    endtask

    // receiver holds off while the sender keeps offering transactions
    task automatic test_output_backpressure();
        logic [QID_W-1:0] qid;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        qid            = QID_W'($urandom_range(NUM_QUEUES - 1));
        hold_request   = LONG_HOLD_CYCLES;
        for (int n = 0; n < 60; n++) begin
            if ($urandom_range(99) < 55)
                send_op(pick_push(), qid, pick_value());
            else
                send_op(pick_pop(), qid, pick_value());
        end
        wait_for_results();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_PUSH_BACK;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("ran %0d deque operations: directed end cases, four idle and stall mixes",
                 ops_sent);
        $display("and a long receiver hold-off; %0d results checked (%0d empty pops, %0d full)",
                 results_checked, empty_pops, full_pushes);
        if (error_count == 0) begin
            $display("[multi_deque_linked_pool_core] OK");
        end else begin
            $display("[multi_deque_linked_pool_core] ERROR");
        end
        $finish;
    end

endmodule
